// File: rtl/itrd_pkg.sv
// ----------------------------------------------------------------------------
// itrd_pkg: shared types and helpers for the radix digit converter
// Holds the sequencer states, the digit glyph lookup and the byte-wide
// division step that the converter runs once per cycle.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int unsigned ValueWidth = 63;
  localparam int unsigned RadixWidth = 5;
  localparam int unsigned CharWidth  = 7;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned ChunkWidth = 8;
  // The value is padded to a whole number of bytes for the long division.
  localparam int unsigned WorkWidth  = 64;
  localparam int unsigned ChunkCount = WorkWidth / ChunkWidth;
  localparam int unsigned ChunkCntW  = $clog2(ChunkCount);

  localparam logic [RadixWidth-1:0] RADIX_MIN = 5'd2;
  localparam logic [RadixWidth-1:0] RADIX_MAX = 5'd16;

  localparam logic [CharWidth-1:0] CHAR_ZERO = 7'h30;  // '0'
  localparam logic [CharWidth-1:0] CHAR_A    = 7'h41;  // 'A'
  localparam logic [CharWidth-1:0] CHAR_NONE = 7'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [ChunkWidth-1:0] quot;
    logic [DigitWidth-1:0] rem;
  } div_step_t;

  // Divides {rem, data_in} by radix, one quotient bit per inner step.
  // The running remainder stays below radix, so it fits in four bits.
  function automatic div_step_t div_step(logic [DigitWidth-1:0] rem,
                                         logic [ChunkWidth-1:0] data_in,
                                         logic [RadixWidth-1:0] radix);
    logic [RadixWidth-1:0] r;
    logic [ChunkWidth-1:0] q;
    div_step_t             res;
    r = {1'b0, rem};
    q = '0;
    for (int i = ChunkWidth - 1; i >= 0; i--) begin
      r = {r[DigitWidth-1:0], data_in[i]};
      if (r >= radix) begin
        r    = r - radix;
        q[i] = 1'b1;
      end
    end
    res.quot = q;
    res.rem  = r[DigitWidth-1:0];
    return res;
  endfunction

  function automatic logic [CharWidth-1:0] digit_glyph(logic [DigitWidth-1:0] d);
    logic [CharWidth-1:0] ch;
    if (d < 4'd10) begin
      ch = CHAR_ZERO + {3'b000, d};
    end else begin
      ch = CHAR_A + {3'b000, d - 4'd10};
    end
    return ch;
  endfunction

endpackage

// File: rtl/integer_to_radix_digits_unit.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit: integer to base-N ASCII digit converter
// Repeatedly divides the value by the radix with a byte-wide divide step,
// stores the remainders and then streams them out most significant first.
// ----------------------------------------------------------------------------
// Each digit takes one pass of the shared byte divide step over the whole value,
//   one byte at a time; once every digit is stored, the digits stream out
//   one digit per cycle, most significant first, up to 63 digits per item.
// A rejected radix gives its single error result in the next cycle.
// Throughput: one item at a time; busy_o stays high until the last digit read.
// Reset clears the sequencer and result strobes; the digit memory needs none.
module integer_to_radix_digits_unit
  import itrd_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [ValueWidth-1:0] value_i,
  input  logic [RadixWidth-1:0] radix_i,
  output logic                  digit_valid_o,
  output logic [CharWidth-1:0]  digit_char_o,
  output logic                  last_o,
  output logic                  bad_radix_o
);

  localparam int unsigned Depth = (MAX_DIGITS < 63) ? MAX_DIGITS : 63;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  state_e                state_q, state_d;
  logic [WorkWidth-1:0]  val_q, val_d;
  logic [RadixWidth-1:0] radix_q, radix_d;
  logic [DigitWidth-1:0] rem_q, rem_d;
  logic [ChunkCntW-1:0]  chunk_q, chunk_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [AddrW-1:0]      ptr_q, ptr_d;

  logic                  emit_v_q, emit_last_q, bad_q;
  logic [DigitWidth-1:0] rd_q;

  logic [DigitWidth-1:0] mem [Depth];

  div_step_t             step;
  logic                  accept;
  logic                  radix_bad;
  logic                  wr_en;
  logic                  rd_en;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign radix_bad = (radix_i < RADIX_MIN) || (radix_i > RADIX_MAX);
  assign step      = div_step(rem_q, val_q[WorkWidth-1 -: ChunkWidth], radix_q);

  always_comb begin
    state_d = state_q;
    val_d   = val_q;
    radix_d = radix_q;
    rem_d   = rem_q;
    chunk_d = chunk_q;
    count_d = count_q;
    ptr_d   = ptr_q;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !radix_bad) begin
          val_d   = {1'b0, value_i};
          radix_d = radix_i;
          rem_d   = '0;
          chunk_d = '0;
          count_d = '0;
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        // The quotient byte shifts in at the bottom as the dividend leaves the top.
        val_d   = {val_q[WorkWidth-ChunkWidth-1:0], step.quot};
        rem_d   = step.rem;
        chunk_d = chunk_q + 1'b1;
        if (chunk_q == ChunkCntW'(ChunkCount - 1)) begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
          rem_d   = '0;
          if ((val_d != '0) && (count_q < CntW'(Depth - 1))) begin
            state_d = ST_DIVIDE;
          end else begin
            ptr_d   = count_q[AddrW-1:0];
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        rd_en = 1'b1;
        if (ptr_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q - 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      emit_v_q    <= 1'b0;
      emit_last_q <= 1'b0;
      bad_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      emit_v_q    <= rd_en;
      emit_last_q <= rd_en && (ptr_q == '0);
      bad_q       <= accept && radix_bad;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    radix_q <= radix_d;
    rem_q   <= rem_d;
    chunk_q <= chunk_d;
    count_q <= count_d;
    ptr_q   <= ptr_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AddrW-1:0]] <= step.rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[ptr_q];
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign digit_valid_o = emit_v_q || bad_q;
  assign digit_char_o  = bad_q ? CHAR_NONE : digit_glyph(rd_q);
  assign last_o        = bad_q || emit_last_q;
  assign bad_radix_o   = bad_q;

  // Digit results and error results never share a cycle.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit_v_q && bad_q))
    else $error("digit and error result in the same cycle");

  // Every cycle in the emit state produces a digit result in the next cycle.
  a_emit_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |=> (digit_valid_o && !bad_radix_o))
    else $error("emit cycle without a following digit result");

  // A rejected radix yields exactly one final error result next cycle.
  a_bad_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && ((radix_i < RADIX_MIN) || (radix_i > RADIX_MAX)))
    |=> (digit_valid_o && bad_radix_o && last_o && (digit_char_o == CHAR_NONE) && !busy_o))
    else $error("bad radix not reported as a single final result");

  // The division loop always writes at least one digit before emitting.
  a_divide_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE && state_d == ST_EMIT) |-> wr_en)
    else $error("left the divide loop without storing a digit");

endmodule

// File: bench/tb_integer_to_radix_digits_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_radix_digits_unit: self-checking bench for the digit converter
// Feeds values and radices through the start/busy command port. A built-in
// predictor expands each accepted value into its digit characters, and the
// monitor checks the streamed digits against them in order.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_digits_unit;
  import itrd_pkg::*;

  localparam int unsigned MaxDigits = 64;
  localparam int unsigned DigitCap  = (MaxDigits < 63) ? MaxDigits : 63;
  localparam int unsigned RandomReqs = 300;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic [RadixWidth-1:0] radix;
  } conv_req_t;

  typedef struct packed {
    logic [CharWidth-1:0] ch;
    logic                 last;
    logic                 bad;
  } digit_result_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  start_i   = 1'b0;
  logic [ValueWidth-1:0] value_i   = '0;
  logic [RadixWidth-1:0] radix_i   = '0;
  logic                  busy_o;
  logic                  digit_valid_o;
  logic [CharWidth-1:0]  digit_char_o;
  logic                  last_o;
  logic                  bad_radix_o;

  conv_req_t     pending_reqs[$];
  digit_result_t expected_digits[$];
  int unsigned   gap_left    = 0;
  int unsigned   error_count = 0;

  integer_to_radix_digits_unit #(
    .MAX_DIGITS(MaxDigits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .value_i      (value_i),
    .radix_i      (radix_i),
    .digit_valid_o(digit_valid_o),
    .digit_char_o (digit_char_o),
    .last_o       (last_o),
    .bad_radix_o  (bad_radix_o)
  );

  always #2 clk_i = ~clk_i;

  // Expands one value into the digit characters it should produce, most
  // significant first. The division stops early once the buffer is full.
  function automatic void predict_digits(logic [ValueWidth-1:0] value,
                                         logic [RadixWidth-1:0] radix);
    logic [DigitWidth-1:0] rems[0:63];
    logic [ValueWidth-1:0] rest;
    logic [ValueWidth-1:0] base;
    logic [DigitWidth-1:0] d;
    digit_result_t         res;
    int unsigned           n;
    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      res.ch   = CHAR_NONE;
      res.last = 1'b1;
      res.bad  = 1'b1;
      expected_digits.push_back(res);
      return;
    end
    rest = value;
    base = ValueWidth'(radix);
    n    = 0;
    do begin
      rems[n] = DigitWidth'(rest % base);
      n++;
      rest = rest / base;
    end while (rest != 0 && n < DigitCap);
    for (int unsigned k = 0; k < n; k++) begin
      d        = rems[n - 1 - k];
      res.ch   = (d < 10) ? CHAR_ZERO + CharWidth'(d) : CHAR_A + CharWidth'(d - 10);
      res.last = (k == n - 1);
      res.bad  = 1'b0;
      expected_digits.push_back(res);
    end
  endfunction

  // Mostly back-to-back or short pauses, now and then a long one.
  function automatic int unsigned draw_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic conv_req_t random_req();
    conv_req_t   req;
    logic [63:0] raw;
    int unsigned sel;
    raw = {$urandom(), $urandom()};
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      req.value = '0;
    end else if (sel == 1) begin
      req.value = '1;
    end else if (sel < 6) begin
      req.value = raw[ValueWidth-1:0];
    end else begin
      // Short values keep most conversions quick.
      req.value = raw[ValueWidth-1:0] & ((63'd1 << $urandom_range(1, 62)) - 63'd1);
    end
    if ($urandom_range(0, 9) == 0) begin
      sel       = $urandom_range(0, 16);
      req.radix = (sel < 2) ? RadixWidth'(sel) : RadixWidth'(sel + 15);
    end else begin
      req.radix = RadixWidth'($urandom_range(2, 16));
    end
    return req;
  endfunction

  // Driver: a transfer happens when start is high and busy is low.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predict_digits(value_i, radix_i);
        gap_left = draw_gap();
        if (gap_left == 0 && pending_reqs.size() != 0) begin
          {value_i, radix_i} <= pending_reqs.pop_front();
        end else begin
          start_i <= 1'b0;
        end
      end else if (!start_i) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0) begin
          {value_i, radix_i} <= pending_reqs.pop_front();
          start_i            <= 1'b1;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expected digit.
  always @(posedge clk_i) begin
    digit_result_t exp_res;
    if (rst_ni && digit_valid_o !== 1'b0) begin
      if (expected_digits.size() == 0) begin
        $display("%0t: unexpected result: char %h last %b bad %b", $time,
                 digit_char_o, last_o, bad_radix_o);
        error_count++;
      end else begin
        exp_res = expected_digits.pop_front();
        if (digit_char_o !== exp_res.ch || last_o !== exp_res.last ||
            bad_radix_o !== exp_res.bad) begin
          $display("%0t: mismatch: expected char %h last %b bad %b, got char %h last %b bad %b",
                   $time, exp_res.ch, exp_res.last, exp_res.bad,
                   digit_char_o, last_o, bad_radix_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    // Every valid base at the largest value gives the longest digit strings.
    for (int unsigned r = 2; r <= 16; r++) begin
      pending_reqs.push_back('{value: '1, radix: RadixWidth'(r)});
    end
    pending_reqs.push_back('{value: '0, radix: 5'd10});
    pending_reqs.push_back('{value: '0, radix: 5'd2});
    pending_reqs.push_back('{value: 63'd1, radix: 5'd2});
    pending_reqs.push_back('{value: 63'h0123456789ABCDEF, radix: 5'd16});
    pending_reqs.push_back('{value: 63'h7EDCBA9876543210, radix: 5'd16});
    // Rejected bases, at both ends of the illegal ranges.
    pending_reqs.push_back('{value: '1, radix: 5'd0});
    pending_reqs.push_back('{value: 63'd5, radix: 5'd1});
    pending_reqs.push_back('{value: '0, radix: 5'd17});
    pending_reqs.push_back('{value: 63'd255, radix: 5'd31});
    for (int unsigned i = 0; i < RandomReqs; i++) begin
      pending_reqs.push_back(random_req());
    end
    gap_left = draw_gap();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_reqs.size() != 0 || start_i) @(posedge clk_i);
    while (expected_digits.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
